// ===== src/positional_array_list_defines.svh =====
// Assertion macros for the positional array list.
// Used by the top level; expects clk and rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pal_pkg.sv =====
// Shared types and constants for the positional array list.
// No dependencies.
package pal_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 16;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   at;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== src/positional_array_list.sv =====
// Positional array list: an ordered list of up to MAX_ENTRIES 32-bit entries
// kept in a chain of cells, one entry per cell. Each transaction on the input
// stream is an insert, get, delete or clear; each yields exactly one result
// transaction with ok, data and the count held afterward. The block takes one
// request per cycle while out_tready keeps up: the whole chain shifts in
// parallel in the cycle a request is accepted, and the result lands in an
// output register in the next cycle. in_tready stays high while the output
// register is empty or being drained, so throughput is one request per clock.
// capacity (cfg port, reset 16) limits how many entries inserts may fill;
// values above MAX_ENTRIES act as MAX_ENTRIES. Entries are not cleared; clear
// only resets the count, and only entries below the count are ever read.
// Depends on pal_pkg, pal_cell and positional_array_list_defines.svh.
`include "positional_array_list_defines.svh"

module positional_array_list
  import pal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write: capacity
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] position (signed), [47:16] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data, [36:32] count, [39:37] zero
  output logic [0:0]  out_tuser   // [0] ok
);

  localparam int MAG_W = POS_W - 1;

  // ---------------------------------------------------------------- state
  logic [CNT_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]  count_r;

  // ---------------------------------------------------------------- decode
  op_t              req_op;
  logic             pos_neg;
  logic [MAG_W-1:0] pos_mag;
  logic [MAG_W-1:0] held_ext;
  logic [CNT_W-1:0] held_m1;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] ins_at, get_at;
  logic             in_acc;
  cell_cmd_t        cmd;

  assign req_op   = op_t'(in_tuser);
  assign pos_neg  = in_tdata[POS_W-1];
  assign pos_mag  = in_tdata[MAG_W-1:0];
  assign held_ext = {{(MAG_W-CNT_W){1'b0}}, held_r};
  assign held_m1  = held_r - 1'b1;
  assign limit    = (capacity_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity_r;

  // clamped positions; insert at held appends
  assign ins_at = pos_neg ? '0 :
                  (pos_mag > held_ext) ? held_r[IDX_W-1:0] : pos_mag[IDX_W-1:0];
  assign get_at = pos_neg ? '0 :
                  (pos_mag >= held_ext) ? held_m1[IDX_W-1:0] : pos_mag[IDX_W-1:0];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- cell chain
  logic [DATA_W-1:0] cell_entry [MAX_ENTRIES];
  logic [DATA_W-1:0] rd_chain   [MAX_ENTRIES+1];

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_entry[i-1];
    end
    if (i == MAX_ENTRIES-1) begin : g_last
      assign right_d = cell_entry[i];
    end else begin : g_mid_r
      assign right_d = cell_entry[i+1];
    end

    pal_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_in      (rd_chain[i]),
      .rd_out     (rd_chain[i+1]),
      .entry      (cell_entry[i])
    );
  end

  // ---------------------------------------------------------------- request
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.at    = get_at;
    cmd.value = in_tdata[POS_W +: DATA_W];
    ok_nxt    = 1'b0;
    data_nxt  = '0;
    held_nxt  = held_r;
    case (req_op)
      OP_INSERT: begin
        ok_nxt = (held_r < limit);
        cmd.at = ins_at;
        if (in_acc && ok_nxt) begin
          cmd.op   = CELL_INS;
          held_nxt = held_r + 1'b1;
        end
      end
      OP_GET: begin
        ok_nxt   = (held_r != '0);
        data_nxt = ok_nxt ? rd_chain[MAX_ENTRIES] : '0;
      end
      OP_DELETE: begin
        ok_nxt = !pos_neg && (pos_mag < held_ext);
        cmd.at = pos_mag[IDX_W-1:0];
        if (in_acc && ok_nxt) begin
          cmd.op   = CELL_DEL;
          held_nxt = held_m1;
        end
      end
      OP_CLEAR: begin
        ok_nxt = 1'b1;
        if (in_acc) begin
          held_nxt = '0;
        end
      end
      default: ok_nxt = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CNT_W'(16);
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r    <= ok_nxt;
      data_r  <= data_nxt;
      count_r <= held_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {3'b000, count_r, data_r};
  assign out_tuser[0] = ok_r;

  // ---------------------------------------------------------------- checks
  `PAL_ASSERT_NOW(a_held_bound, 1'b1, held_r <= CNT_W'(MAX_ENTRIES), "count beyond built size")
  `PAL_ASSERT_NEXT(a_clear_result, in_acc && (in_tuser == OP_CLEAR),
    out_tvalid && out_tuser[0] && (out_tdata[36:32] == '0), "clear result wrong")
  `PAL_ASSERT_NEXT(a_insert_count, in_acc && (in_tuser == OP_INSERT) && (held_r < limit),
    held_r == CNT_W'($past(held_r) + 1'b1), "insert did not bump count")

endmodule

// ===== src/pal_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on pal_pkg.
module pal_cell
  import pal_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  idx,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  input  logic [DATA_W-1:0] rd_in,
  output logic [DATA_W-1:0] rd_out,
  output logic [DATA_W-1:0] entry
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INS: begin
        if (idx == cmd.at) begin
          entry_nxt = cmd.value;
        end else if (idx > cmd.at) begin
          entry_nxt = left_data;
        end
      end
      CELL_DEL: begin
        if (idx >= cmd.at) begin
          entry_nxt = right_data;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // read cascade: the addressed cell ORs its entry in
  assign rd_out = rd_in | ((idx == cmd.at) ? entry_r : '0);
  assign entry  = entry_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for positional_array_list: drives requests and capacity
// writes, predicts every result in-house and compares the result stream field by field.
// Depends on pal_pkg and the positional_array_list RTL.
`timescale 1ns / 100ps

module tb_top
  import pal_pkg::*;
();

  localparam int LIMIT_CYCLES = 500_000;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // DUT signals, all inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [15:0] position (signed), [47:16] value
  logic [1:0]  in_tuser   = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] data, [36:32] count, [39:37] zero
  logic [0:0]  out_tuser;         // [0] ok

  // Shadow copy of the list, updated at each accepted request
  logic [DATA_W-1:0] shadow_slots [MAX_ENTRIES];
  int                held_now = 0;
  int                cap_now  = 16;

  list_result_t pending_results [$];
  int           errors     = 0;
  int           cycles     = 0;
  int           stall_left = 0;
  bit           no_gaps    = 1'b0;

  always #5 clk = ~clk;

  positional_array_list uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Applies one request to the shadow list and returns what the block must answer.
  // Capacity above the built size behaves as the built size.
  function automatic list_result_t list_apply(op_t op, logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
    list_result_t r;
    int p;
    int at;
    int lim;
    int i;
    r   = '0;
    p   = $signed(pos);
    lim = (cap_now > MAX_ENTRIES) ? MAX_ENTRIES : cap_now;
    case (op)
      OP_INSERT: begin
        if (held_now < lim) begin
          at = (p < 0) ? 0 : ((p > held_now) ? held_now : p);
          for (i = held_now; i > at; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[at] = val;
          held_now++;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (held_now > 0) begin
          at = (p < 0) ? 0 : ((p >= held_now) ? held_now - 1 : p);
          r.data = shadow_slots[at];
          r.ok   = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 0 && p < held_now) begin
          for (i = p; i + 1 < held_now; i++) shadow_slots[i] = shadow_slots[i+1];
          held_now--;
          r.ok = 1'b1;
        end
      end
      default: begin
        held_now = 0;
        r.ok     = 1'b1;
      end
    endcase
    r.count = held_now[CNT_W-1:0];
    return r;
  endfunction

  // Idle length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Position near the live range, sometimes negative or anywhere in 16 bits
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_W'($urandom);
    if (r == 1) return -POS_W'($urandom_range(1, 4));
    return POS_W'($urandom_range(0, held_now + 1));
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Sender: optional gap, then hold valid until the transaction is taken.
  // Valid stays high into the next request when no gap follows.
  task automatic push_request(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, pos};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(list_apply(op, pos, val));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity is only changed with nothing in flight; the extra cycles just give margin.
  task automatic write_capacity(logic [4:0] v);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cap_now = int'(v);
    cfg_valid <= 1'b0;
  endtask

  // Weighted toward inserts so the list gets deep; clears are rare.
  task automatic push_random_request();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      op = OP_INSERT;
    end else if (r < 70) begin
      op = OP_GET;
    end else if (r < 97) begin
      op = OP_DELETE;
    end else begin
      op = OP_CLEAR;
    end
    push_request(op, pick_position(), $urandom);
  endtask

  task automatic run_random(int n);
    repeat (n) push_random_request();
  endtask

  // Empty list, clamped positions at both ends, out-of-range deletes,
  // last-entry delete, clear, and get after clear.
  task automatic test_directed();
    push_request(OP_GET,    16'h0000, $urandom);
    push_request(OP_DELETE, 16'h0000, $urandom);
    push_request(OP_CLEAR,  16'h0000, $urandom);
    push_request(OP_INSERT, 16'h7FFF, 32'hFFFF_FFFF);
    push_request(OP_INSERT, 16'h8000, 32'h0000_0000);
    push_request(OP_INSERT, 16'h0001, 32'hA5A5_A5A5);
    push_request(OP_INSERT, 16'h0003, 32'h5A5A_5A5A);
    push_request(OP_GET,    16'hFFFF, $urandom);
    push_request(OP_GET,    16'h7FFF, $urandom);
    push_request(OP_GET,    16'h0002, $urandom);
    push_request(OP_DELETE, 16'hFFFF, $urandom);
    push_request(OP_DELETE, 16'h0004, $urandom);
    push_request(OP_DELETE, 16'h7FFF, $urandom);
    push_request(OP_DELETE, 16'h8000, $urandom);
    push_request(OP_DELETE, 16'h0001, $urandom);
    push_request(OP_DELETE, 16'h0002, $urandom);
    push_request(OP_GET,    16'h0001, $urandom);
    push_request(OP_CLEAR,  16'hFFFF, $urandom);
    push_request(OP_GET,    16'h0000, $urandom);
    push_request(OP_DELETE, 16'h0000, $urandom);
    push_request(OP_INSERT, 16'h0000, 32'h1234_5678);
    push_request(OP_INSERT, 16'h0000, 32'h8765_4321);
    push_request(OP_GET,    16'h0001, $urandom);
  endtask

  // Capacity zero, one, and the largest register value (saturates)
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    push_request(OP_INSERT, 16'h0000, $urandom);
    push_request(OP_INSERT, 16'h7FFF, $urandom);
    push_request(OP_GET,    16'h0000, $urandom);
    run_random(20);
    write_capacity(5'd1);
    push_request(OP_CLEAR,  16'h0000, $urandom);
    push_request(OP_INSERT, 16'h0005, $urandom);
    push_request(OP_INSERT, 16'h0000, $urandom);
    run_random(60);
    write_capacity(5'd31);
    run_random(150);
  endtask

  // Lower capacity below the count: entries stay, inserts fail until deletes
  task automatic test_capacity_shrink();
    write_capacity(5'd16);
    push_request(OP_CLEAR, 16'h0000, $urandom);
    repeat (12) push_request(OP_INSERT, pick_position(), $urandom);
    write_capacity(5'd3);
    run_random(60);
  endtask

  // Sender stops repeatedly until the result stream has caught up
  task automatic test_result_drain();
    write_capacity(5'd16);
    repeat (10) begin
      run_random(10);
      drain_results();
    end
  endtask

  task automatic test_random_mix();
    logic [4:0] caps [8] = '{5'd2, 5'd8, 5'd17, 5'd16, 5'd5, 5'd12, 5'd1, 5'd16};
    foreach (caps[k]) begin
      write_capacity(caps[k]);
      no_gaps = (k == 3);     // one phase at full rate on both sides
      run_random(130);
    end
    no_gaps = 1'b0;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin : rx_stall
    int g;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = pick_gap();
      out_tready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  // Result checker: each result transaction against the oldest prediction
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual ok=%b data=%h count=%0d",
                 $time, out_tuser[0], out_tdata[31:0], out_tdata[36:32]);
      end else begin
        want = pending_results.pop_front();
        check_field("ok",    32'(want.ok),    32'(out_tuser[0]));
        check_field("data",  want.data,       out_tdata[31:0]);
        check_field("count", 32'(want.count), 32'(out_tdata[36:32]));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity_limits();
    test_capacity_shrink();
    test_result_drain();
    test_random_mix();
    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
